>>> design/mrq_pkg.sv
// Shared types, constants and helpers for the mailbox ring queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package mrq_pkg;

  localparam int DEPTH     = 16;
  localparam int MSG_WIDTH = 32;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 5;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_POST   = 2'd0;
  localparam logic [OP_W-1:0] OP_URGENT = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HANDED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;      // operation transfers in this cycle
    logic load_now;  // load result register from the operation itself
    logic load_ram;  // load result register from the ring read data
  } mrq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic take_hit;  // incoming operation is a take that pops an entry
  } mrq_sts_t;

  // Step a ring position, wrapping to zero at the live capacity
  function automatic logic [PTR_W-1:0] mrq_advance(input logic [PTR_W-1:0] pos,
                                                   input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] sum;
    sum = CNT_W'(pos) + CNT_W'(1);
    if (sum >= cap) begin
      return '0;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> design/mrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module mrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/mrq_ctrl.sv
// Controller for the mailbox ring queue: input handshake, read wait state,
// result valid. Depends on mrq_pkg for command and status types.
module mrq_ctrl
  import mrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  mrq_sts_t sts,
  output mrq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;

  // Hold input while a take waits on the ring or the result is stalled
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign cmd.exec     = accept;
  assign cmd.load_now = accept && !sts.take_hit;
  assign cmd.load_ram = (state == S_READ);

  // Advance the state machine
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && sts.take_hit) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Set result valid on load, drop it on transfer
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_now || cmd.load_ram) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> design/mrq_datapath.sv
// Datapath for the mailbox ring queue: positions, count, capacity register,
// ring storage and result register. Depends on mrq_pkg and mrq_ram.
module mrq_datapath
  import mrq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data,
  input  logic [OP_W-1:0]      op,
  input  logic [MSG_WIDTH-1:0] message,
  input  logic                 waiter_present,
  input  mrq_cmd_t             cmd,
  output mrq_sts_t             sts,
  output logic [STATUS_W-1:0]  status,
  output logic [MSG_WIDTH-1:0] message_out,
  output logic [CNT_W-1:0]     fill_count
);

  logic [CAP_W-1:0]     capacity_reg;
  logic [PTR_W-1:0]     rd_pos;
  logic [PTR_W-1:0]     wr_pos;
  logic [CNT_W-1:0]     held;
  logic [PTR_W-1:0]     rd_pos_next;
  logic [PTR_W-1:0]     wr_pos_next;
  logic [CNT_W-1:0]     held_next;
  logic [CNT_W-1:0]     cap;
  logic [PTR_W-1:0]     rd_pos_back;
  logic [STATUS_W-1:0]  res_status;
  logic [MSG_WIDTH-1:0] res_msg;
  logic                 ram_wr_en;
  logic [PTR_W-1:0]     ram_wr_addr;
  logic                 ram_rd_en;
  logic [MSG_WIDTH-1:0] ram_rd_data;
  logic                 is_post;

  // Clamp the capacity register to 1..DEPTH
  always_comb begin
    if (capacity_reg == '0) begin
      cap = CNT_W'(1);
    end else if (capacity_reg > CAP_W'(DEPTH)) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = CNT_W'(capacity_reg);
    end
  end

  assign rd_pos_back = (rd_pos == '0) ? PTR_W'(cap - CNT_W'(1)) : rd_pos - PTR_W'(1);
  assign is_post     = (op == OP_POST) || (op == OP_URGENT);
  assign sts.take_hit = (op == OP_TAKE) && (held != '0);

  // Work out the next ring state and the immediate result
  always_comb begin
    rd_pos_next = rd_pos;
    wr_pos_next = wr_pos;
    held_next   = held;
    res_status  = ST_DONE;
    res_msg     = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = wr_pos;
    ram_rd_en   = 1'b0;
    if (is_post) begin
      if (waiter_present) begin
        res_status = ST_HANDED;
        res_msg    = message;
      end else if (held >= cap) begin
        res_status = ST_FULL;
      end else if (op == OP_URGENT) begin
        rd_pos_next = rd_pos_back;
        ram_wr_en   = 1'b1;
        ram_wr_addr = rd_pos_back;
        held_next   = held + CNT_W'(1);
      end else begin
        ram_wr_en   = 1'b1;
        wr_pos_next = mrq_advance(wr_pos, cap);
        held_next   = held + CNT_W'(1);
      end
    end else if (op == OP_TAKE) begin
      if (held == '0) begin
        res_status = ST_EMPTY;
      end else begin
        ram_rd_en   = 1'b1;
        rd_pos_next = mrq_advance(rd_pos, cap);
        held_next   = held - CNT_W'(1);
      end
    end else begin
      if (waiter_present) begin
        res_status = ST_REFUSED;
      end else begin
        rd_pos_next = '0;
        wr_pos_next = '0;
        held_next   = '0;
      end
    end
  end

  // Update capacity, positions and count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_reg <= CAP_W'(DEPTH);
      rd_pos       <= '0;
      wr_pos       <= '0;
      held         <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity_reg <= cfg_wr_data;
      end
      if (cmd.exec) begin
        rd_pos <= rd_pos_next;
        wr_pos <= wr_pos_next;
        held   <= held_next;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      status      <= res_status;
      message_out <= res_msg;
      fill_count  <= held_next;
    end else if (cmd.load_ram) begin
      status      <= ST_DONE;
      message_out <= ram_rd_data;
      fill_count  <= held;
    end
  end

  mrq_ram #(
    .WIDTH (MSG_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.exec && ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (message),
    .rd_en   (cmd.exec && ram_rd_en),
    .rd_addr (rd_pos),
    .rd_data (ram_rd_data)
  );

endmodule

>>> design/mailbox_ring_queue_core.sv
// Top level of the mailbox ring queue: controller plus datapath.
// Depends on mrq_pkg, mrq_ctrl, mrq_datapath and mrq_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation: op, message,
//   waiter_present. Output channel (out_valid / out_stall) returns exactly one
//   result per operation: status, message_out, fill_count. The user must write
//   the capacity register with cfg_wr_en/cfg_wr_data while idle; not enforced.
// Results and throughput:
//   Post, urgent post, clear and a take on an empty ring: result is valid in
//   the cycle after the transfer; a new operation can follow every cycle
//   unless the result is stalled. A take that pops a message: result passes
//   the ring RAM's registered read port, then the result register.
// Stalls:
//   The result register holds its value while out_stall is high; the input
//   stalls only while that register is full and stalled, or a pop is reading.
// Reset:
//   rst (synchronous) empties the ring, zeroes both positions and sets the
//   capacity to the full depth of 16. Ring contents are not cleared.
module mailbox_ring_queue_core
  import mrq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [MSG_WIDTH-1:0] message,
  input  logic                 waiter_present,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [MSG_WIDTH-1:0] message_out,
  output logic [CNT_W-1:0]     fill_count
);

  mrq_cmd_t cmd;
  mrq_sts_t sts;

  mrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .op             (op),
    .message        (message),
    .waiter_present (waiter_present),
    .cmd            (cmd),
    .sts            (sts),
    .status         (status),
    .message_out    (message_out),
    .fill_count     (fill_count)
  );

endmodule

>>> tb/tb_mailbox_ring_queue_core.sv
// Testbench for mailbox_ring_queue_core: directed and random mailbox traffic
// checked against an in-bench model of the ring. Depends on mrq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_mailbox_ring_queue_core;
  import mrq_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 4;
  localparam int PHASE_OPS   = 150;

  typedef struct {
    logic [OP_W-1:0]      code;
    logic [MSG_WIDTH-1:0] word;
    logic                 waiter;
  } mbox_op_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [MSG_WIDTH-1:0] word;
    logic [CNT_W-1:0]     fill;
  } mbox_res_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CAP_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      op;
  logic [MSG_WIDTH-1:0] message;
  logic                 waiter_present;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  logic [MSG_WIDTH-1:0] message_out;
  logic [CNT_W-1:0]     fill_count;

  mailbox_ring_queue_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .message        (message),
    .waiter_present (waiter_present),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .message_out    (message_out),
    .fill_count     (fill_count)
  );

  // Mirror of the mailbox state
  logic [MSG_WIDTH-1:0] ring_words [DEPTH];
  logic [DEPTH-1:0]     ring_written;
  int                   head_pos;
  int                   tail_pos;
  int                   held;
  logic [CAP_W-1:0]     cap_reg;

  mbox_res_t pending_results[$];
  int        mismatch_count;
  int        ops_sent;
  int        results_checked;
  int        cap_writes;
  int        status_seen [5];
  int        cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ring position step, wrapping at the live capacity
  function automatic int ring_next(input int pos, input int cap);
    return (pos + 1 >= cap) ? 0 : pos + 1;
  endfunction

  // Apply one operation to the mirror and return the result it should produce
  function automatic mbox_res_t mailbox_apply(input mbox_op_t it);
    mbox_res_t r;
    int        cap;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
    r.status = ST_DONE;
    r.word   = '0;
    if (it.code == OP_POST || it.code == OP_URGENT) begin
      if (it.waiter) begin
        r.status = ST_HANDED;
        r.word   = it.word;
      end else if (held >= cap) begin
        r.status = ST_FULL;
      end else if (it.code == OP_URGENT) begin
        head_pos = (head_pos == 0) ? cap - 1 : head_pos - 1;
        ring_words[head_pos]   = it.word;
        ring_written[head_pos] = 1'b1;
        held++;
      end else begin
        ring_words[tail_pos]   = it.word;
        ring_written[tail_pos] = 1'b1;
        tail_pos = ring_next(tail_pos, cap);
        held++;
      end
    end else if (it.code == OP_TAKE) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        held--;
        r.word   = ring_words[head_pos];
        head_pos = ring_next(head_pos, cap);
      end
    end else begin
      if (it.waiter) begin
        r.status = ST_REFUSED;
      end else begin
        head_pos = 0;
        tail_pos = 0;
        held     = 0;
      end
    end
    r.fill = CNT_W'(held);
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one operation, hold it until transfer, then record its expected result
  task automatic send_op(input logic [OP_W-1:0] code, input logic [MSG_WIDTH-1:0] word,
                         input logic waiter);
    mbox_op_t it;
    int       gap;
    it.code   = code;
    it.word   = word;
    it.waiter = waiter;
    // never pop a ring entry that has not been written since reset
    if (it.code == OP_TAKE && held != 0 && !ring_written[head_pos]) it.code = OP_POST;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= it.code;
    message        <= it.word;
    waiter_present <= it.waiter;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(mailbox_apply(it));
    ops_sent++;
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the capacity register; call only while idle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = value;
    cap_writes++;
  endtask

  // Empty take, refused clear, handoff, urgent wrap to the top entry, clear
  task automatic test_directed_basics();
    send_op(OP_TAKE, 32'h1234_5678, 1'b1);
    send_op(OP_CLEAR, '0, 1'b1);
    send_op(OP_POST, 32'h0000_0000, 1'b0);
    send_op(OP_POST, 32'hFFFF_FFFF, 1'b0);
    send_op(OP_URGENT, 32'h5555_5555, 1'b1);
    send_op(OP_URGENT, 32'hAAAA_AAAA, 1'b0);
    send_op(OP_TAKE, '0, 1'b0);
    send_op(OP_TAKE, '0, 1'b1);
    send_op(OP_CLEAR, '0, 1'b0);
    send_op(OP_TAKE, '0, 1'b0);
  endtask

  // Smallest capacity: full drops, waiter precedence over full, zero acting as one
  task automatic test_capacity_limits();
    write_capacity(CAP_W'(1));
    send_op(OP_POST, 32'hCAFE_0001, 1'b0);
    send_op(OP_POST, 32'hCAFE_0002, 1'b0);
    send_op(OP_URGENT, 32'hCAFE_0003, 1'b0);
    send_op(OP_POST, 32'hCAFE_0004, 1'b1);
    send_op(OP_TAKE, '0, 1'b0);
    send_op(OP_URGENT, 32'hCAFE_0005, 1'b0);
    send_op(OP_TAKE, '0, 1'b0);
    write_capacity(CAP_W'(0));
    send_op(OP_POST, 32'hBEEF_0006, 1'b0);
    send_op(OP_POST, 32'hBEEF_0007, 1'b0);
    send_op(OP_TAKE, '0, 1'b0);
  endtask

  // Phases of random traffic, each with its own capacity and fill tendency
  task automatic test_random_traffic();
    logic [CAP_W-1:0]     caps [9];
    logic [OP_W-1:0]      code;
    logic [MSG_WIDTH-1:0] word;
    int                   r;
    int                   post_lim;
    int                   urgent_lim;
    int                   take_lim;
    caps = '{CAP_W'(31), CAP_W'(2), CAP_W'(16), CAP_W'(5), CAP_W'(0),
             CAP_W'($urandom_range(1, 16)), CAP_W'(16), CAP_W'($urandom_range(0, 31)),
             CAP_W'(1)};
    for (int ph = 0; ph < 9; ph++) begin
      write_capacity(caps[ph]);
      case (ph % 3)
        0: begin post_lim = 30; urgent_lim = 48; take_lim = 95; end
        1: begin post_lim = 45; urgent_lim = 70; take_lim = 96; end
        default: begin post_lim = 20; urgent_lim = 32; take_lim = 94; end
      endcase
      for (int i = 0; i < PHASE_OPS; i++) begin
        r = $urandom_range(0, 99);
        if (r < post_lim) code = OP_POST;
        else if (r < urgent_lim) code = OP_URGENT;
        else if (r < take_lim) code = OP_TAKE;
        else code = OP_CLEAR;
        r = $urandom_range(0, 15);
        word = (r == 0) ? '0 : ((r == 1) ? '1 : MSG_WIDTH'($urandom));
        send_op(code, word, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Random stalls on the result side, with stretches of none
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      n = pick_gap();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    mbox_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no operation outstanding: status %0d message_out %h fill_count %0d",
               status, message_out, fill_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status <= ST_REFUSED) status_seen[want.status]++;
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
        if (message_out !== want.word) begin
          $error("message_out: expected %h, actual %h", want.word, message_out);
          mismatch_count++;
        end
        if (fill_count !== want.fill) begin
          $error("fill_count: expected %0d, actual %0d", want.fill, fill_count);
          mismatch_count++;
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sequence the tests
  initial begin
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    op             <= OP_POST;
    message        <= '0;
    waiter_present <= 1'b0;
    head_pos     = 0;
    tail_pos     = 0;
    held         = 0;
    cap_reg      = CAP_W'(DEPTH);
    ring_written = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basics();
    test_capacity_limits();
    test_random_traffic();
    drain_pipeline();

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end
    $display("Covered %0d operations and %0d results over %0d capacity settings.",
             ops_sent, results_checked, cap_writes);
    $display("Results by status: done %0d, empty %0d, full %0d, handed %0d, refused %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
